@@ hdl/ratio_to_float32_core_macros.svh @@
// assertion macros shared by the ratio to float32 core
`ifndef RATIO_TO_FLOAT32_CORE_MACROS_SVH
`define RATIO_TO_FLOAT32_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define R2F_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("r2f check failed");

// next-cycle implication, disabled during reset
`define R2F_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("r2f check failed");

`else

`define R2F_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define R2F_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/r2f_pkg.sv @@
// shared types, constants and helpers of the ratio to float32 core
`default_nettype none

package r2f_pkg;

    localparam int WORD_BITS = 64;
    localparam int FRAC_BITS = 23;
    localparam int QUO_BITS  = FRAC_BITS + 1;
    localparam int EXP_BIAS  = 127;
    localparam int POS_W     = 7;
    localparam int EXP_W     = 8;

    // exponent window in which the scaling shift stays within 0..63
    localparam logic signed [EXP_W-1:0] EXP_MAX = EXP_W'(FRAC_BITS);
    localparam logic signed [EXP_W-1:0] EXP_MIN = EXP_W'(FRAC_BITS - WORD_BITS + 1);

    // data handed from cell to cell along the divider chain
    typedef struct packed {
        logic [WORD_BITS-1:0]        rem;
        logic [QUO_BITS-1:0]         low;
        logic [QUO_BITS-1:0]         quo;
        logic [WORD_BITS-1:0]        den;
        logic signed [EXP_W-1:0]     expo;
        logic                        zero;
        logic                        ok;
    } cell_t;

    // position of the highest set bit counted from 1, zero for a zero word
    function automatic logic [POS_W-1:0] lead_pos(input logic [WORD_BITS-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                p = POS_W'(i + 1);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hdl/r2f_front.sv @@
// front end: leading-one search, exponent estimate and correction, numerator scaling
`default_nettype none

`include "ratio_to_float32_core_macros.svh"

module r2f_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [r2f_pkg::WORD_BITS-1:0] in_num,
    input  wire logic [r2f_pkg::WORD_BITS-1:0] in_den,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output r2f_pkg::cell_t                     out_data
);
    import r2f_pkg::*;

    // stage a: operands and leading-one positions
    logic                    a_vld_reg;
    logic [WORD_BITS-1:0]    a_num_reg;
    logic [WORD_BITS-1:0]    a_den_reg;
    logic [POS_W-1:0]        a_ln_reg;
    logic [POS_W-1:0]        a_ld_reg;
    logic                    a_dz_reg;
    logic                    a_nz_reg;
    logic                    a_adv;

    // stage b: corrected exponent
    logic                    b_vld_reg;
    logic [WORD_BITS-1:0]    b_num_reg;
    logic [WORD_BITS-1:0]    b_den_reg;
    logic [POS_W-1:0]        b_ln_reg;
    logic signed [EXP_W-1:0] b_exp_reg;
    logic                    b_dz_reg;
    logic                    b_nz_reg;
    logic                    b_adv;
    logic signed [EXP_W-1:0] b_diff;
    logic                    b_neg;
    logic [POS_W-1:0]        b_mag;
    logic [WORD_BITS-1:0]    b_src;
    logic [WORD_BITS-1:0]    b_shifted;
    logic                    b_lt;
    logic signed [EXP_W-1:0] b_exp_next;

    // stage c: scaled numerator, entry of the divider chain
    logic                    c_vld_reg;
    cell_t                   c_data_reg;
    cell_t                   c_data_next;
    logic                    c_adv;
    logic signed [EXP_W-1:0] c_sh_full;
    logic [5:0]              c_sh;
    logic                    c_range_ok;
    logic                    c_ovf;
    logic [WORD_BITS-1:0]    c_scaled;

    assign a_adv    = !a_vld_reg || b_adv;
    assign b_adv    = !b_vld_reg || c_adv;
    assign c_adv    = !c_vld_reg || out_ready;
    assign in_ready = a_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_adv) begin
            a_vld_reg <= in_valid;
        end
        if (a_adv && in_valid) begin
            a_num_reg <= in_num;
            a_den_reg <= in_den;
            a_ln_reg  <= lead_pos(in_num);
            a_ld_reg  <= lead_pos(in_den);
            a_dz_reg  <= (in_den == '0);
            a_nz_reg  <= (in_num == '0);
        end
    end

    // estimate from leading-one positions, lower by one if n < d * 2^e
    always_comb begin
        b_diff     = EXP_W'({1'b0, a_ln_reg}) - EXP_W'({1'b0, a_ld_reg});
        b_neg      = b_diff[EXP_W-1];
        b_mag      = b_neg ? POS_W'(-b_diff) : POS_W'(b_diff);
        b_src      = b_neg ? a_num_reg : a_den_reg;
        b_shifted  = b_src << b_mag;
        b_lt       = b_neg ? (b_shifted < a_den_reg) : (a_num_reg < b_shifted);
        b_exp_next = b_diff - EXP_W'(b_lt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_adv) begin
            b_vld_reg <= a_vld_reg;
        end
        if (b_adv && a_vld_reg) begin
            b_num_reg <= a_num_reg;
            b_den_reg <= a_den_reg;
            b_ln_reg  <= a_ln_reg;
            b_exp_reg <= b_exp_next;
            b_dz_reg  <= a_dz_reg;
            b_nz_reg  <= a_nz_reg;
        end
    end

    // shift range and overflow checks, then scale the numerator
    always_comb begin
        c_sh_full  = EXP_MAX - b_exp_reg;
        c_sh       = c_sh_full[5:0];
        c_range_ok = (b_exp_reg <= EXP_MAX) && (b_exp_reg >= EXP_MIN);
        c_ovf      = ({1'b0, b_ln_reg} + {2'b00, c_sh}) > 8'(WORD_BITS);
        c_scaled   = b_num_reg << c_sh;

        c_data_next      = '0;
        c_data_next.rem  = {{QUO_BITS{1'b0}}, c_scaled[WORD_BITS-1:QUO_BITS]};
        c_data_next.low  = c_scaled[QUO_BITS-1:0];
        c_data_next.den  = b_den_reg;
        c_data_next.expo = b_exp_reg;
        c_data_next.zero = b_nz_reg;
        c_data_next.ok   = !b_dz_reg && (b_nz_reg || (c_range_ok && !c_ovf));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (c_adv) begin
            c_vld_reg <= b_vld_reg;
        end
        if (c_adv && b_vld_reg) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_data  = c_data_reg;

    // a request that passes the checks enters the chain with an exponent in window
    `R2F_ASSERT_IMPL(a_front_exp_window, aclk, aresetn,
        c_vld_reg && c_data_reg.ok && !c_data_reg.zero,
        (c_data_reg.expo <= EXP_MAX) && (c_data_reg.expo >= EXP_MIN))

endmodule

`default_nettype wire

@@ hdl/r2f_cell.sv @@
// one restoring divider cell: produces one quotient bit per request
`default_nettype none

`include "ratio_to_float32_core_macros.svh"

module r2f_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire r2f_pkg::cell_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output r2f_pkg::cell_t      out_data
);
    import r2f_pkg::*;

    logic                 vld_reg;
    cell_t                data_reg;
    cell_t                data_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 qbit;

    assign in_ready = !vld_reg || out_ready;

    // shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial         = {in_data.rem, in_data.low[QUO_BITS-1]};
        diff          = trial - {1'b0, in_data.den};
        qbit          = (trial >= {1'b0, in_data.den});
        data_next     = in_data;
        data_next.rem = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        data_next.low = {in_data.low[QUO_BITS-2:0], 1'b0};
        data_next.quo = {in_data.quo[QUO_BITS-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // partial remainder always stays below the divisor
    `R2F_ASSERT_IMPL(a_cell_rem_below_den, aclk, aresetn,
        vld_reg && data_reg.ok && !data_reg.zero,
        data_reg.rem < data_reg.den)

endmodule

`default_nettype wire

@@ hdl/r2f_round.sv @@
// rounding, renormalization and packing into the output register
`default_nettype none

`include "ratio_to_float32_core_macros.svh"

module r2f_round (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire r2f_pkg::cell_t in_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [31:0]         m_float_bits,
    output logic                m_valid_res
);
    import r2f_pkg::*;

    logic                m_valid_reg;
    logic [31:0]         bits_reg;
    logic [31:0]         bits_next;
    logic                res_reg;
    logic [WORD_BITS:0]  twice_rem;
    logic [WORD_BITS:0]  den_ext;
    logic                round_up;
    logic [QUO_BITS:0]   q_round;
    logic [FRAC_BITS:0]  mant;
    logic [EXP_W:0]      bexp;

    assign in_ready = !m_valid_reg || m_ready;

    // round to nearest, ties to even; a carry to 2^24 halves the significand
    always_comb begin
        twice_rem = {in_data.rem, 1'b0};
        den_ext   = {1'b0, in_data.den};
        round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && in_data.quo[0]);
        q_round   = {1'b0, in_data.quo} + (QUO_BITS + 1)'(round_up);
        mant      = q_round[QUO_BITS] ? q_round[QUO_BITS:1] : q_round[FRAC_BITS:0];
        bexp      = {in_data.expo[EXP_W-1], in_data.expo} + (EXP_W + 1)'(EXP_BIAS)
                    + (EXP_W + 1)'(q_round[QUO_BITS]);
        if (in_data.ok && !in_data.zero) begin
            bits_next = {1'b0, bexp[EXP_W-1:0], mant[FRAC_BITS-1:0]};
        end else begin
            bits_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            bits_reg <= bits_next;
            res_reg  <= in_data.ok;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_float_bits = bits_reg;
    assign m_valid_res  = res_reg;

    // a checked nonzero quotient leaves the chain normalized
    `R2F_ASSERT_IMPL(a_round_quo_normal, aclk, aresetn,
        in_valid && in_data.ok && !in_data.zero,
        in_data.quo[QUO_BITS-1])

    // a failed request carries an all-zero pattern
    `R2F_ASSERT_IMPL(a_round_fail_zero, aclk, aresetn,
        m_valid_reg && !res_reg,
        bits_reg == '0)

    // a request taken from the chain shows up at the output next cycle
    `R2F_ASSERT_NEXT(a_round_take_shows, aclk, aresetn,
        in_valid && in_ready,
        m_valid_reg)

endmodule

`default_nettype wire

@@ hdl/ratio_to_float32_core.sv @@
// Path from input request to result: 3 front stages, 24 divider cells, 1 rounding
// and output register stage. Throughput: one request per cycle unless m_ready stalls;
// each divider cell resolves one quotient bit and passes its remainder to the next
// cell, so 24 requests are in the chain at once.
// Stalls fill bubbles stage by stage; the input stays ready while any stage is empty.
// Reset: synchronous active-low aresetn clears all stage valid bits; no data is held.
`default_nettype none

module ratio_to_float32_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_numerator,
    input  wire logic [63:0] s_denominator,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_float_bits,
    output logic             m_valid_res
);
    import r2f_pkg::*;

    cell_t chain_data [0:QUO_BITS];
    logic  chain_vld  [0:QUO_BITS];
    logic  chain_rdy  [0:QUO_BITS];

    // exponent search and numerator scaling
    r2f_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_num    (s_numerator),
        .in_den    (s_denominator),
        .out_valid (chain_vld[0]),
        .out_ready (chain_rdy[0]),
        .out_data  (chain_data[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
        r2f_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_vld[i]),
            .in_ready  (chain_rdy[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_vld[i+1]),
            .out_ready (chain_rdy[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // rounding and result register
    r2f_round u_round (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (chain_vld[QUO_BITS]),
        .in_ready     (chain_rdy[QUO_BITS]),
        .in_data      (chain_data[QUO_BITS]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_float_bits (m_float_bits),
        .m_valid_res  (m_valid_res)
    );

endmodule

`default_nettype wire
